// ----- sv/ptt_pkg.sv -----
// Package for the periodic timer table: field widths, command and status codes,
// sequencer states and the structs passed between the table's modules.
// Depends on nothing; every other file of the block but ptt_ram uses it.
package ptt_pkg;

  localparam int ID_W         = 32;
  localparam int PER_W        = 32;
  localparam int TIME_W       = 48;
  localparam int RESULT_LIMIT = 16;
  localparam int CNT_W        = $clog2(RESULT_LIMIT);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    FN_SET   = 2'd0,
    FN_KILL  = 2'd1,
    FN_TICK  = 2'd2,
    FN_CLEAR = 2'd3
  } ptt_func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } ptt_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SET_FIN,
    S_SELECT,
    S_RESULT
  } ptt_state_t;

  typedef enum logic [1:0] {
    UOP_KEEP,
    UOP_FIRE,
    UOP_SUM
  } ptt_uop_t;

  typedef struct packed {
    logic [ID_W-1:0]   key;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] due;
  } ptt_slot_t;

  typedef struct packed {
    logic              key_eq;
    logic              key_lt;
    logic              due_le;
    logic              cand_lt;
    logic [TIME_W-1:0] sum;
    logic [TIME_W-1:0] cand;
  } ptt_ures_t;

  typedef struct packed {
    ptt_status_t       status;
    logic              fired_valid;
    logic [ID_W-1:0]   fired_id;
    logic              next_due_valid;
    logic [TIME_W-1:0] next_due_ms;
    logic              last;
  } ptt_res_t;

endpackage

// ----- sv/ptt_in_if.sv -----
// Command channel of the periodic timer table: valid, ready and one command item.
// Depends on ptt_pkg for the field widths.
interface ptt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [ptt_pkg::ID_W-1:0]    timer_id;
  logic [ptt_pkg::PER_W-1:0]   delay_ms;
  logic [ptt_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, func, timer_id, delay_ms, now_ms, input ready);
  modport sink (input valid, func, timer_id, delay_ms, now_ms, output ready);
endinterface

// ----- sv/ptt_out_if.sv -----
// Result channel of the periodic timer table: valid, ready and one result item.
// Depends on ptt_pkg for the field widths.
interface ptt_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic                        fired_valid;
  logic [ptt_pkg::ID_W-1:0]    fired_id;
  logic                        next_due_valid;
  logic [ptt_pkg::TIME_W-1:0]  next_due_ms;
  logic                        last;

  modport source (output valid, status, fired_valid, fired_id, next_due_valid,
                  next_due_ms, last, input ready);
  modport sink (input valid, status, fired_valid, fired_id, next_due_valid,
                next_due_ms, last, output ready);
endinterface

// ----- sv/periodic_timer_table.sv -----
// Top level of the periodic timer table: sequencer, slot valid bits and output register.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if, ptt_ram and ptt_unit.
//
// The table holds up to MAX_TIMERS periodic timers in one RAM, read one slot per
// cycle by a sequencer that drives a single shared add and compare unit. Set, kill
// and tick each make one pass over the slots, which finds the id, the lowest free
// slot, rearms due timers and forms the earliest due time; set then writes its slot
// in the S_SET_FIN state. A tick then makes one more pass for each fired id it
// reports, so ids come out in ascending order, at most sixteen. Clear is done at the
// edge that accepts it. Each result is registered in the sequencer, waits there while
// the output register is stalled, and then moves to the output register. cmd.ready
// stays low from an accepted command until its final result has been loaded there;
// the output register then holds it while the next command is taken.
module periodic_timer_table #(
  parameter int MAX_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ptt_in_if.sink      cmd,
  ptt_out_if.source   rsp
);

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int SW = $bits(ptt_pkg::ptt_slot_t);

  ptt_pkg::ptt_state_t          state, state_next;
  logic [MAX_TIMERS-1:0]        slot_valid, slot_valid_next;
  logic [MAX_TIMERS-1:0]        fired, fired_next;
  logic [MAX_TIMERS-1:0]        remaining;
  logic                         p_vld, p_vld_next;
  logic                         out_valid, out_valid_next;
  ptt_pkg::ptt_res_t            out_r, out_next;
  ptt_pkg::ptt_res_t            res, res_next;

  ptt_pkg::ptt_func_t           c_func, c_func_next;
  logic [ptt_pkg::ID_W-1:0]     c_id, c_id_next;
  logic [ptt_pkg::PER_W-1:0]    c_delay, c_delay_next;
  logic [ptt_pkg::TIME_W-1:0]   c_now, c_now_next;

  logic [CW-1:0]                idx, idx_next;
  logic [AW-1:0]                p_idx, p_idx_next;
  logic                         best_any, best_any_next;
  logic [ptt_pkg::TIME_W-1:0]   best_due, best_due_next;
  logic                         match, match_next;
  logic [AW-1:0]                match_idx, match_idx_next;
  logic                         free_found, free_found_next;
  logic [AW-1:0]                free_idx, free_idx_next;
  logic                         pick_found, pick_found_next;
  logic [AW-1:0]                pick_idx, pick_idx_next;
  logic [ptt_pkg::ID_W-1:0]     pick_key, pick_key_next;
  logic [ptt_pkg::CNT_W-1:0]    nemit, nemit_next;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  ptt_pkg::ptt_slot_t           ram_wdata;
  logic [SW-1:0]                ram_rdata;
  ptt_pkg::ptt_slot_t           rd_slot;

  ptt_pkg::ptt_uop_t            uop;
  logic [ptt_pkg::PER_W-1:0]    u_period;
  ptt_pkg::ptt_ures_t           ures;

  logic                         scan_done;
  logic                         take_min;
  logic [AW-1:0]                set_slot;
  logic [ptt_pkg::TIME_W-1:0]   set_due;

  function automatic ptt_pkg::ptt_res_t make_res(
    input ptt_pkg::ptt_status_t       st,
    input logic                       fv,
    input logic [ptt_pkg::ID_W-1:0]   fid,
    input logic                       any,
    input logic [ptt_pkg::TIME_W-1:0] due,
    input logic                       lst
  );
    ptt_pkg::ptt_res_t r;
    r.status         = st;
    r.fired_valid    = fv;
    r.fired_id       = fid;
    r.next_due_valid = any;
    r.next_due_ms    = any ? due : '0;
    r.last           = lst;
    return r;
  endfunction

  ptt_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TIMERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_slot = ram_rdata;

  ptt_unit u_unit (
    .op       (uop),
    .now      (c_now),
    .period   (u_period),
    .due      (rd_slot.due),
    .key      (rd_slot.key),
    .ref_key  (c_id),
    .best_key (pick_key),
    .best_due (best_due),
    .res      (ures)
  );

  assign scan_done = (idx == CW'(MAX_TIMERS)) && !p_vld;
  assign set_slot  = match ? match_idx : free_idx;
  assign set_due   = (!best_any || ures.cand_lt) ? ures.sum : best_due;

  assign cmd.ready          = (state == ptt_pkg::S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_r.status;
  assign rsp.fired_valid    = out_r.fired_valid;
  assign rsp.fired_id       = out_r.fired_id;
  assign rsp.next_due_valid = out_r.next_due_valid;
  assign rsp.next_due_ms    = out_r.next_due_ms;
  assign rsp.last           = out_r.last;

  always_comb begin
    state_next      = state;
    slot_valid_next = slot_valid;
    fired_next      = fired;
    p_vld_next      = 1'b0;
    p_idx_next      = p_idx;
    out_valid_next  = out_valid;
    out_next        = out_r;
    res_next        = res;
    c_func_next     = c_func;
    c_id_next       = c_id;
    c_delay_next    = c_delay;
    c_now_next      = c_now;
    idx_next        = idx;
    best_any_next   = best_any;
    best_due_next   = best_due;
    match_next      = match;
    match_idx_next  = match_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    pick_found_next = pick_found;
    pick_idx_next   = pick_idx;
    pick_key_next   = pick_key;
    nemit_next      = nemit;
    ram_we          = 1'b0;
    ram_waddr       = p_idx;
    ram_wdata       = rd_slot;
    uop             = ptt_pkg::UOP_KEEP;
    u_period        = rd_slot.period;
    take_min        = 1'b0;
    remaining       = fired;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    if ((state == ptt_pkg::S_SCAN || state == ptt_pkg::S_SELECT) &&
        (idx < CW'(MAX_TIMERS))) begin
      p_vld_next = 1'b1;
      p_idx_next = idx[AW-1:0];
      idx_next   = idx + CW'(1);
    end

    unique case (state)
      ptt_pkg::S_IDLE: begin
        if (cmd.valid) begin
          c_func_next     = ptt_pkg::ptt_func_t'(cmd.func);
          c_id_next       = cmd.timer_id;
          c_delay_next    = (cmd.delay_ms == '0) ? ptt_pkg::PER_W'(1) : cmd.delay_ms;
          c_now_next      = cmd.now_ms;
          idx_next        = '0;
          best_any_next   = 1'b0;
          match_next      = 1'b0;
          free_found_next = 1'b0;
          fired_next      = '0;
          nemit_next      = '0;
          if (ptt_pkg::ptt_func_t'(cmd.func) == ptt_pkg::FN_CLEAR) begin
            slot_valid_next = '0;
            res_next = make_res(ptt_pkg::STS_OK, 1'b0, '0, 1'b0, '0, 1'b1);
            state_next = ptt_pkg::S_RESULT;
          end else begin
            state_next = ptt_pkg::S_SCAN;
          end
        end
      end

      ptt_pkg::S_SCAN: begin
        if (p_vld) begin
          if (slot_valid[p_idx]) begin
            if (c_func == ptt_pkg::FN_TICK) begin
              uop      = ptt_pkg::UOP_FIRE;
              take_min = 1'b1;
              if (ures.due_le) begin
                ram_we               = 1'b1;
                ram_wdata.key        = rd_slot.key;
                ram_wdata.period     = rd_slot.period;
                ram_wdata.due        = ures.sum;
                fired_next[p_idx]    = 1'b1;
              end
            end else if (ures.key_eq) begin
              match_next     = 1'b1;
              match_idx_next = p_idx;
            end else begin
              take_min = 1'b1;
            end
          end else if (!free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = p_idx;
          end
          if (take_min && (!best_any || ures.cand_lt)) begin
            best_any_next = 1'b1;
            best_due_next = ures.cand;
          end
        end
        if (scan_done) begin
          unique case (c_func)
            ptt_pkg::FN_SET: begin
              if (match || free_found) begin
                state_next = ptt_pkg::S_SET_FIN;
              end else begin
                res_next = make_res(ptt_pkg::STS_FULL, 1'b0, '0, best_any, best_due, 1'b1);
                state_next = ptt_pkg::S_RESULT;
              end
            end
            ptt_pkg::FN_KILL: begin
              if (match) begin
                slot_valid_next[match_idx] = 1'b0;
                res_next = make_res(ptt_pkg::STS_OK, 1'b0, '0, best_any, best_due, 1'b1);
              end else begin
                res_next = make_res(ptt_pkg::STS_NOT_FOUND, 1'b0, '0, best_any, best_due,
                                    1'b1);
              end
              state_next = ptt_pkg::S_RESULT;
            end
            ptt_pkg::FN_TICK: begin
              if (|fired) begin
                idx_next        = '0;
                pick_found_next = 1'b0;
                state_next      = ptt_pkg::S_SELECT;
              end else begin
                res_next = make_res(ptt_pkg::STS_OK, 1'b0, '0, best_any, best_due, 1'b1);
                state_next = ptt_pkg::S_RESULT;
              end
            end
            ptt_pkg::FN_CLEAR: begin
              state_next = ptt_pkg::S_IDLE;
            end
          endcase
        end
      end

      ptt_pkg::S_SET_FIN: begin
        uop                       = ptt_pkg::UOP_SUM;
        u_period                  = c_delay;
        ram_we                    = 1'b1;
        ram_waddr                 = set_slot;
        ram_wdata.key             = c_id;
        ram_wdata.period          = c_delay;
        ram_wdata.due             = ures.sum;
        slot_valid_next[set_slot] = 1'b1;
        res_next   = make_res(ptt_pkg::STS_OK, 1'b0, '0, 1'b1, set_due, 1'b1);
        state_next = ptt_pkg::S_RESULT;
      end

      ptt_pkg::S_SELECT: begin
        if (p_vld && fired[p_idx] && (!pick_found || ures.key_lt)) begin
          pick_found_next = 1'b1;
          pick_idx_next   = p_idx;
          pick_key_next   = rd_slot.key;
        end
        if (scan_done) begin
          remaining[pick_idx] = 1'b0;
          fired_next = remaining;
          res_next = make_res(ptt_pkg::STS_OK, 1'b1, pick_key, best_any, best_due,
                              (remaining == '0) ||
                              (nemit == ptt_pkg::CNT_W'(ptt_pkg::RESULT_LIMIT - 1)));
          nemit_next = nemit + ptt_pkg::CNT_W'(1);
          state_next = ptt_pkg::S_RESULT;
        end
      end

      ptt_pkg::S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_next       = res;
          if (res.last) begin
            state_next = ptt_pkg::S_IDLE;
          end else begin
            idx_next        = '0;
            pick_found_next = 1'b0;
            state_next      = ptt_pkg::S_SELECT;
          end
        end
      end

      default: begin
        state_next = ptt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptt_pkg::S_IDLE;
      slot_valid <= '0;
      fired      <= '0;
      p_vld      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      fired      <= fired_next;
      p_vld      <= p_vld_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_next;
    res        <= res_next;
    c_func     <= c_func_next;
    c_id       <= c_id_next;
    c_delay    <= c_delay_next;
    c_now      <= c_now_next;
    idx        <= idx_next;
    p_idx      <= p_idx_next;
    best_any   <= best_any_next;
    best_due   <= best_due_next;
    match      <= match_next;
    match_idx  <= match_idx_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    pick_found <= pick_found_next;
    pick_idx   <= pick_idx_next;
    pick_key   <= pick_key_next;
    nemit      <= nemit_next;
  end

endmodule

// ----- sv/ptt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ptt_unit.sv -----
// Shared compare and add unit of the timer table: saturating due-time add,
// due and key compares, and the running-minimum compare for one slot.
// Depends on ptt_pkg.
module ptt_unit (
  input  ptt_pkg::ptt_uop_t             op,
  input  logic [ptt_pkg::TIME_W-1:0]    now,
  input  logic [ptt_pkg::PER_W-1:0]     period,
  input  logic [ptt_pkg::TIME_W-1:0]    due,
  input  logic [ptt_pkg::ID_W-1:0]      key,
  input  logic [ptt_pkg::ID_W-1:0]      ref_key,
  input  logic [ptt_pkg::ID_W-1:0]      best_key,
  input  logic [ptt_pkg::TIME_W-1:0]    best_due,
  output ptt_pkg::ptt_ures_t            res
);

  logic [ptt_pkg::TIME_W:0]   wide;
  logic [ptt_pkg::TIME_W-1:0] sum;
  logic [ptt_pkg::TIME_W-1:0] cand;
  logic                       due_le;

  assign wide   = {1'b0, now} + {{(ptt_pkg::TIME_W + 1 - ptt_pkg::PER_W){1'b0}}, period};
  assign sum    = wide[ptt_pkg::TIME_W] ? ptt_pkg::TIME_MAX : wide[ptt_pkg::TIME_W-1:0];
  assign due_le = (due <= now);

  always_comb begin
    unique case (op)
      ptt_pkg::UOP_KEEP: cand = due;
      ptt_pkg::UOP_FIRE: cand = due_le ? sum : due;
      ptt_pkg::UOP_SUM:  cand = sum;
      default:           cand = due;
    endcase
  end

  always_comb begin
    res.key_eq  = (key == ref_key);
    res.key_lt  = (key < best_key);
    res.due_le  = due_le;
    res.cand_lt = (cand < best_due);
    res.sum     = sum;
    res.cand    = cand;
  end

endmodule

// ----- sv/ptt_checker.sv -----
// Port-level checker for the periodic timer table and the bind that attaches it.
// Depends on ptt_pkg and on the ports of periodic_timer_table.
module ptt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [1:0]                  status,
  input logic                        fired_valid,
  input logic [ptt_pkg::ID_W-1:0]    fired_id,
  input logic                        next_due_valid,
  input logic [ptt_pkg::TIME_W-1:0]  next_due_ms,
  input logic                        last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(fired_id) &&
      $stable(next_due_ms) && $stable(last))
    else $error("result item changed while stalled");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while the previous one is still in work");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && fired_valid |-> status == ptt_pkg::STS_OK)
    else $error("fired item with an error status");

  a_nofire_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !fired_valid |-> last && fired_id == '0)
    else $error("item without a fired id is not a single final item");

  a_empty_due: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !next_due_valid |-> next_due_ms == '0)
    else $error("next due time reported for an empty table");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .fired_valid    (rsp.fired_valid),
  .fired_id       (rsp.fired_id),
  .next_due_valid (rsp.next_due_valid),
  .next_due_ms    (rsp.next_due_ms),
  .last           (rsp.last)
);
